[design/lps3_pkg.sv]
// Package for the 3D lattice six-neighbor stencil block.
// Holds sizes, register indexes and the beat types; no dependencies.
package lps3_pkg;

    localparam int VALUE_BITS = 32;
    localparam int FRAC_BITS  = 24;
    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int ROW_BITS   = 6;
    localparam int COL_BITS   = 6;
    localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
    localparam int PLANE_DEPTH = MAX_ROWS * MAX_COLS;

    localparam int SIZE_X_BITS  = 12;
    localparam int SIZE_YZ_BITS = 7;
    localparam logic [SIZE_X_BITS-1:0]  SIZE_X_RESET  = 12'd50;
    localparam logic [SIZE_YZ_BITS-1:0] SIZE_YZ_RESET = 7'd50;

    // Six face neighbors; the mean divides by the same count.
    localparam int NB_COUNT  = 6;
    localparam int SUM_BITS  = VALUE_BITS + 3;
    localparam int DIV_DIGIT = 8;
    localparam int DIV_STEPS = 5;
    localparam int DIV_BITS  = DIV_DIGIT * DIV_STEPS;
    localparam int REM_BITS  = 3;
    localparam int PROD_BITS = 2 * VALUE_BITS;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 2;
    localparam logic [REG_IDX_BITS-1:0] REG_SIZE_X = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_SIZE_Z = 2'd2;

    typedef struct packed {
        logic [VALUE_BITS-1:0] voxel_value;
        logic [VALUE_BITS-1:0] site_weight;
        logic                  flush;
    } t_in_beat;

    typedef struct packed {
        logic [VALUE_BITS-1:0] new_value;
        logic                  last;
    } t_out_beat;

endpackage

[design/lattice_propagator_stencil_3d_top.sv]
// Top level of the 3D lattice six-neighbor stencil step.
// Depends on lps3_pkg and instantiates lps3_ram for the two planes and the weights.
//
// Usage: interior voxels enter on the input channel in raster order, plane
// (slow), row, then column (fast), each beat carrying the old value and the
// site weight. The first plane is only stored. From the second plane on, each
// beat produces one result beat for the voxel at the same row and column of the
// previous plane: the mean of its six face neighbors times its weight, with a
// neighbor outside the box replaced by the voxel itself. After the last plane,
// one flush beat per voxel drains the final plane, and its last result carries
// last. Beats that do not fit the phase (a voxel while draining, a flush while
// planes are still expected) are taken and dropped.
// Sequencing: a stored or dropped beat leaves the block idle for the next beat.
// A beat that yields a result steps through the sequential reads of the plane
// memories (one read port each), the shared accumulator, the divide by six at 8
// bits a cycle, the weight multiply and the load of the output register.
// The result is valid once the output register is loaded, and o_in_stall stays
// high until then. A stalled result holds in the output register; the block
// waits in its last step until the register frees up.
// Reset clears the sizes to 50 and the position to zero; memory contents are
// not cleared. Any size write starts a new volume.
module lattice_propagator_stencil_3d_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  lps3_pkg::t_in_beat                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output lps3_pkg::t_out_beat                  o_out_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lps3_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [lps3_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [lps3_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);

    import lps3_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_DIV,
        S_MUL,
        S_OUT
    } t_state;

    localparam logic [2:0] READ_LAST = 3'd3;
    localparam logic [2:0] SUM_LAST  = 3'(NB_COUNT - 1);
    localparam logic [2:0] DIV_LAST  = 3'(DIV_STEPS - 1);

    t_state r_state;
    logic [2:0] r_step;

    logic [SIZE_X_BITS-1:0]  r_size_x;
    logic [SIZE_YZ_BITS-1:0] r_size_y;
    logic [SIZE_YZ_BITS-1:0] r_size_z;

    logic [SIZE_X_BITS-1:0] r_pos_x;
    logic [ROW_BITS-1:0]    r_pos_y;
    logic [COL_BITS-1:0]    r_pos_z;
    logic [SIZE_X_BITS-1:0] n_pos_x;
    logic [ROW_BITS-1:0]    n_pos_y;
    logic [COL_BITS-1:0]    n_pos_z;

    logic              r_out_valid;
    t_out_beat         r_out_data;

    // Item and neighbor registers.
    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] r_weight_in;
    logic                  r_flush;
    logic                  r_x_one;
    logic [VALUE_BITS-1:0] r_centre;
    logic [VALUE_BITS-1:0] r_back;
    logic [VALUE_BITS-1:0] r_up;
    logic [VALUE_BITS-1:0] r_down;
    logic [VALUE_BITS-1:0] r_left;
    logic [VALUE_BITS-1:0] r_right;
    logic [VALUE_BITS-1:0] r_weight;
    logic [SUM_BITS-1:0]   r_acc;
    logic [DIV_BITS-1:0]   r_div;
    logic [REM_BITS-1:0]   r_rem;
    logic [PROD_BITS-1:0]  r_prod;

    logic [SIZE_X_BITS-1:0]  eff_x;
    logic [SIZE_YZ_BITS-1:0] eff_y;
    logic [SIZE_YZ_BITS-1:0] eff_z;
    logic drain;
    logic ignore;
    logic in_take;
    logic out_take;
    logic row_end;
    logic plane_end;
    logic has_up;
    logic has_down;
    logic has_left;
    logic has_right;

    logic [ADDR_BITS-1:0] idx;
    logic [ADDR_BITS-1:0] mid_raddr;
    logic [ADDR_BITS-1:0] beh_raddr;
    logic                 first_wr;
    logic                 sum_wr;
    logic                 mid_we;
    logic                 beh_we;
    logic [VALUE_BITS-1:0] mid_wdata;
    logic [VALUE_BITS-1:0] wt_wdata;
    logic [VALUE_BITS-1:0] mid_rdata;
    logic [VALUE_BITS-1:0] beh_rdata;
    logic [VALUE_BITS-1:0] wt_rdata;

    logic [VALUE_BITS-1:0] nb_sel;
    logic [SUM_BITS-1:0]   sum_next;
    logic [DIV_BITS-1:0]   n_div;
    logic [REM_BITS-1:0]   n_rem;
    logic [REM_BITS:0]     trial;
    logic [DIV_BITS-1:0]   div_work;
    logic [REM_BITS-1:0]   rem_work;
    t_out_beat             result;

    logic                    cfg_wr;
    logic [REG_IDX_BITS-1:0] cfg_idx;

    // A zero size reads as one; the row and column sizes are also clamped to 64.
    assign eff_x = (r_size_x == '0) ? SIZE_X_BITS'(1) : r_size_x;
    assign eff_y = (r_size_y == '0) ? SIZE_YZ_BITS'(1) :
                   ((r_size_y > SIZE_YZ_BITS'(MAX_ROWS)) ? SIZE_YZ_BITS'(MAX_ROWS) : r_size_y);
    assign eff_z = (r_size_z == '0) ? SIZE_YZ_BITS'(1) :
                   ((r_size_z > SIZE_YZ_BITS'(MAX_COLS)) ? SIZE_YZ_BITS'(MAX_COLS) : r_size_z);

    assign drain    = (r_pos_x == eff_x);
    assign ignore   = (i_in_data.flush != drain);
    assign in_take  = (r_state == S_IDLE) && i_in_valid;
    assign out_take = r_out_valid && !i_out_stall;

    assign has_up    = (r_pos_y != '0);
    assign has_down  = (({1'b0, r_pos_y} + SIZE_YZ_BITS'(1)) < eff_y);
    assign has_left  = (r_pos_z != '0);
    assign has_right = (({1'b0, r_pos_z} + SIZE_YZ_BITS'(1)) < eff_z);

    // Position of the next beat.
    always_comb begin
        row_end   = (({1'b0, r_pos_z} + SIZE_YZ_BITS'(1)) >= eff_z);
        plane_end = row_end && !has_down;
        n_pos_z   = row_end ? '0 : r_pos_z + COL_BITS'(1);
        n_pos_y   = r_pos_y;
        n_pos_x   = r_pos_x;
        if (row_end) begin
            n_pos_y = plane_end ? '0 : r_pos_y + ROW_BITS'(1);
        end
        if (plane_end) begin
            n_pos_x = drain ? '0 : r_pos_x + SIZE_X_BITS'(1);
        end
    end

    // Memory addressing: three reads per plane memory, one per step.
    assign idx = {r_pos_y, r_pos_z};

    always_comb begin
        case (r_step)
            3'd0: begin
                mid_raddr = idx;
                beh_raddr = idx;
            end
            3'd1: begin
                mid_raddr = idx + ADDR_BITS'(MAX_COLS);
                beh_raddr = idx - ADDR_BITS'(MAX_COLS);
            end
            default: begin
                mid_raddr = idx + ADDR_BITS'(1);
                beh_raddr = idx - ADDR_BITS'(1);
            end
        endcase
    end

    assign first_wr  = in_take && !ignore && (r_pos_x == '0);
    assign sum_wr    = (r_state == S_SUM) && (r_step == '0);
    assign mid_we    = first_wr || (sum_wr && !r_flush);
    assign beh_we    = sum_wr;
    assign mid_wdata = first_wr ? i_in_data.voxel_value : r_value;
    assign wt_wdata  = first_wr ? i_in_data.site_weight : r_weight_in;

    lps3_ram #(.WIDTH(VALUE_BITS), .DEPTH(PLANE_DEPTH)) u_plane_middle (
        .i_clk   (i_clk),
        .i_we    (mid_we),
        .i_waddr (idx),
        .i_wdata (mid_wdata),
        .i_raddr (mid_raddr),
        .o_rdata (mid_rdata)
    );

    lps3_ram #(.WIDTH(VALUE_BITS), .DEPTH(PLANE_DEPTH)) u_plane_behind (
        .i_clk   (i_clk),
        .i_we    (beh_we),
        .i_waddr (idx),
        .i_wdata (r_centre),
        .i_raddr (beh_raddr),
        .o_rdata (beh_rdata)
    );

    lps3_ram #(.WIDTH(VALUE_BITS), .DEPTH(PLANE_DEPTH)) u_weight_middle (
        .i_clk   (i_clk),
        .i_we    (mid_we),
        .i_waddr (idx),
        .i_wdata (wt_wdata),
        .i_raddr (idx),
        .o_rdata (wt_rdata)
    );

    // One neighbor per cycle into the shared accumulator. A neighbor outside
    // the box, or a plane that does not exist, reads as the center voxel.
    always_comb begin
        case (r_step)
            3'd0:    nb_sel = r_flush ? r_centre : r_value;
            3'd1:    nb_sel = r_x_one ? r_centre : r_back;
            3'd2:    nb_sel = has_up ? r_up : r_centre;
            3'd3:    nb_sel = has_down ? r_down : r_centre;
            3'd4:    nb_sel = has_left ? r_left : r_centre;
            default: nb_sel = has_right ? r_right : r_centre;
        endcase
    end

    assign sum_next = ((r_step == '0) ? '0 : r_acc) + SUM_BITS'(nb_sel);

    // Restoring divide by six, eight quotient bits per cycle.
    always_comb begin
        div_work = r_div;
        rem_work = r_rem;
        trial    = '0;
        for (int i = 0; i < DIV_DIGIT; i++) begin
            trial    = {rem_work, div_work[DIV_BITS-1]};
            div_work = {div_work[DIV_BITS-2:0], 1'b0};
            if (trial >= (REM_BITS+1)'(NB_COUNT)) begin
                rem_work    = REM_BITS'(trial - (REM_BITS+1)'(NB_COUNT));
                div_work[0] = 1'b1;
            end else begin
                rem_work = trial[REM_BITS-1:0];
            end
        end
        n_div = div_work;
        n_rem = rem_work;
    end

    // Truncate back to Q8.24 and saturate when the integer part overflows.
    always_comb begin
        if (r_prod[PROD_BITS-1:FRAC_BITS+VALUE_BITS] != '0) begin
            result.new_value = '1;
        end else begin
            result.new_value = r_prod[FRAC_BITS+VALUE_BITS-1:FRAC_BITS];
        end
        result.last = r_flush && !has_down && !has_right;
    end

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_ADDR_BITS-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_pos_z     <= '0;
            r_size_x    <= SIZE_X_RESET;
            r_size_y    <= SIZE_YZ_RESET;
            r_size_z    <= SIZE_YZ_RESET;
        end else begin
            if (out_take) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take && !ignore) begin
                        if (r_pos_x == '0) begin
                            r_pos_x <= n_pos_x;
                            r_pos_y <= n_pos_y;
                            r_pos_z <= n_pos_z;
                        end else begin
                            r_state <= S_READ;
                            r_step  <= '0;
                        end
                    end
                end
                S_READ: begin
                    if (r_step == READ_LAST) begin
                        r_state <= S_SUM;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_SUM: begin
                    if (r_step == SUM_LAST) begin
                        r_state <= S_DIV;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_DIV: begin
                    if (r_step == DIV_LAST) begin
                        r_state <= S_MUL;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_MUL: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || out_take) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= result;
                        r_pos_x     <= n_pos_x;
                        r_pos_y     <= n_pos_y;
                        r_pos_z     <= n_pos_z;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_SIZE_X: begin
                        r_size_x <= pwdata[SIZE_X_BITS-1:0];
                        r_pos_x  <= '0;
                        r_pos_y  <= '0;
                        r_pos_z  <= '0;
                    end
                    REG_SIZE_Y: begin
                        r_size_y <= pwdata[SIZE_YZ_BITS-1:0];
                        r_pos_x  <= '0;
                        r_pos_y  <= '0;
                        r_pos_z  <= '0;
                    end
                    REG_SIZE_Z: begin
                        r_size_z <= pwdata[SIZE_YZ_BITS-1:0];
                        r_pos_x  <= '0;
                        r_pos_y  <= '0;
                        r_pos_z  <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers; these carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_value     <= i_in_data.voxel_value;
            r_weight_in <= i_in_data.site_weight;
            r_flush     <= i_in_data.flush;
            r_x_one     <= (r_pos_x == SIZE_X_BITS'(1));
        end
        if (r_state == S_READ) begin
            case (r_step)
                3'd1: begin
                    r_centre <= mid_rdata;
                    r_back   <= beh_rdata;
                    r_weight <= wt_rdata;
                end
                3'd2: begin
                    r_down <= mid_rdata;
                    r_up   <= beh_rdata;
                end
                3'd3: begin
                    r_right <= mid_rdata;
                    r_left  <= beh_rdata;
                end
                default: begin
                end
            endcase
        end
        if (r_state == S_SUM) begin
            r_acc <= sum_next;
            if (r_step == SUM_LAST) begin
                r_div <= DIV_BITS'(sum_next);
                r_rem <= '0;
            end
        end
        if (r_state == S_DIV) begin
            r_div <= n_div;
            r_rem <= n_rem;
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_BITS'(r_div[VALUE_BITS-1:0]) * PROD_BITS'(r_weight);
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SIZE_X: prdata = APB_DATA_BITS'(r_size_x);
            REG_SIZE_Y: prdata = APB_DATA_BITS'(r_size_y);
            REG_SIZE_Z: prdata = APB_DATA_BITS'(r_size_z);
            default:    prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[design/lps3_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lps3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
